[hdl/bfg_pkg.sv]
// Package for the battery fuel gauge: widths, discharge curve tables,
// back-end state type and the structs passed between the gauge modules.
// No dependencies.
`timescale 1ns / 1ps

package bfg_pkg;

  localparam int SAMPLE_W = 12;                  // ADC pin reading, mV
  localparam int SUM_W    = 16;                  // burst sum, wraps
  localparam int CNT_W    = 4;                   // samples taken in a burst
  localparam int BURST_W  = 5;                   // holds the burst length itself
  localparam int CAL_W    = 15;                  // gain, unsigned Q1.14
  localparam int MV_W     = 14;                  // battery_mv
  localparam int PCT_W    = 7;                   // charge_percent
  localparam int FRAC_W   = 14;                  // fraction bits of the gain
  localparam int NUM_W    = SUM_W + 1 + CAL_W;   // sum * 2 * gain
  localparam int QMV_W    = NUM_W - FRAC_W;      // unclamped voltage quotient
  localparam int CMV_W    = 13;                  // curve voltages
  localparam int CURVE_N  = 12;
  localparam int IDX_W    = 4;
  localparam int DV_W     = 8;                   // voltage span of a segment
  localparam int DP_W     = 4;                   // percent span of a segment
  localparam int DH_W     = 12;                  // span scaled by burst length
  localparam int DVS_W    = DH_W + FRAC_W;       // percent divider, divisor
  localparam int DIV_W    = 30;                  // percent divider, dividend
  localparam int QP_W     = 4;                   // percent divider, quotient bits
  localparam int Q_DEPTH  = 2;                   // front/back queue, power of two
  localparam int Q_AW     = 1;

  localparam logic [CAL_W-1:0] GAIN_ONE  = 15'd16384;
  localparam logic [MV_W-1:0]  MV_MAX    = 14'd16383;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
  localparam logic [IDX_W-1:0] IDX_TOP   = 4'd0;
  localparam logic [IDX_W-1:0] IDX_BOT   = 4'd11;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RECIP,
    BK_REM,
    BK_SEG,
    BK_PREP,
    BK_PCT_GO,
    BK_PCT_WAIT,
    BK_EMIT
  } bk_state_t;

  typedef struct packed {
    logic             push;
    logic [SUM_W-1:0] sum;
  } q_wr_t;

  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } q_rd_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic            done;
    logic [QP_W-1:0] quot;
  } div_rsp_t;

  // Li-Po discharge curve, highest point first
  function automatic logic [CMV_W-1:0] curve_mv(input logic [IDX_W-1:0] i);
    logic [CMV_W-1:0] v;
    unique case (i)
      4'd0:    v = 13'd4200;
      4'd1:    v = 13'd4100;
      4'd2:    v = 13'd4000;
      4'd3:    v = 13'd3920;
      4'd4:    v = 13'd3850;
      4'd5:    v = 13'd3800;
      4'd6:    v = 13'd3760;
      4'd7:    v = 13'd3720;
      4'd8:    v = 13'd3680;
      4'd9:    v = 13'd3600;
      4'd10:   v = 13'd3500;
      4'd11:   v = 13'd3300;
      default: v = 13'd3300;
    endcase
    return v;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [IDX_W-1:0] i);
    logic [PCT_W-1:0] p;
    unique case (i)
      4'd0:    p = 7'd100;
      4'd1:    p = 7'd90;
      4'd2:    p = 7'd80;
      4'd3:    p = 7'd70;
      4'd4:    p = 7'd60;
      4'd5:    p = 7'd50;
      4'd6:    p = 7'd40;
      4'd7:    p = 7'd30;
      4'd8:    p = 7'd20;
      4'd9:    p = 7'd10;
      4'd10:   p = 7'd5;
      4'd11:   p = 7'd0;
      default: p = 7'd0;
    endcase
    return p;
  endfunction

endpackage

[hdl/bfg_if.sv]
// Valid/ready channel interfaces of the fuel gauge: sample input and result output.
// Depends on bfg_pkg.
`timescale 1ns / 1ps

interface bfg_sample_if;
  import bfg_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_mv;
  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bfg_result_if;
  import bfg_pkg::*;
  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  battery_mv;
  logic [PCT_W-1:0] charge_percent;
  modport source (output valid, output battery_mv, output charge_percent, input ready);
  modport sink   (input valid, input battery_mv, input charge_percent, output ready);
endinterface

[hdl/battery_fuel_gauge.sv]
// Battery fuel gauge top level: calibration register, front end, queue, back end.
// Depends on bfg_pkg, bfg_if, bfg_fifo, bfg_front, bfg_back.
//
// Usage:
//  - sample: one ADC pin reading in mV per beat (valid/ready).
//  - result: battery_mv and charge_percent, one beat per completed burst of
//    SAMPLES_PER_READING samples (valid/ready).
//  - cfg_wen/cfg_wdata: writes the Q1.14 voltage gain; write only while idle.
//  - Throughput: one sample beat per cycle. sample.ready drops only on the last
//    beat of a burst while both queue slots hold sums the back end has not taken.
//  - Path: the last beat of a burst reaches result.valid through the queue,
//    plus any wait there, and the back end; a clamped percent skips the
//    interpolation divider. The back end's pace per reading is set by its
//    sequencer and the 4-step restoring divider, so bursts of 12 or more
//    samples run at full rate.
//  - Reset (rst, synchronous): burst sum and count clear, queue empties, any
//    pending result is dropped, gain returns to 1.0.
//  - A stalled result receiver holds the result beat; the back end then waits
//    with its next reading, the queue fills, and finally sample.ready drops.
`timescale 1ns / 1ps

module battery_fuel_gauge #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [bfg_pkg::CAL_W-1:0] cfg_wdata,
  bfg_sample_if.sink                sample,
  bfg_result_if.source              result
);
  import bfg_pkg::*;

  logic [CAL_W-1:0] cal;
  q_wr_t            qw;
  q_rd_t            qr;
  logic             q_full;
  logic             q_pop;

  // gain register, read by the back end while a reading is worked out
  always_ff @(posedge clk) begin
    if (rst)          cal <= GAIN_ONE;
    else if (cfg_wen) cal <= cfg_wdata;
  end

  // front end: accumulate a burst, push its sum
  bfg_front #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .sample (sample),
    .qw     (qw),
    .q_full (q_full)
  );

  // two-entry queue decouples accumulation from the scaling work
  bfg_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .wr   (qw),
    .pop  (q_pop),
    .rd   (qr),
    .full (q_full)
  );

  // back end: voltage by reciprocal multiply, percent by curve segment
  // lookup and a short divide, result held in an output register
  bfg_back #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qr     (qr),
    .q_pop  (q_pop),
    .cal    (cal),
    .result (result)
  );

endmodule

[hdl/bfg_fifo.sv]
// Short queue of finished burst sums between the gauge front and back ends.
// Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  bfg_pkg::q_wr_t wr,
  input  logic          pop,
  output bfg_pkg::q_rd_t rd,
  output logic          full
);
  import bfg_pkg::*;

  logic [SUM_W-1:0] mem [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_AW:0]    count;

  assign full     = (count == (Q_AW+1)'(Q_DEPTH));
  assign rd.valid = (count != '0);
  assign rd.sum   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)     rd_ptr <= rd_ptr + 1'b1;
      if (wr.push && !pop)      count <= count + 1'b1;
      else if (!wr.push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) mem[wr_ptr] <= wr.sum;
  end

endmodule

[hdl/bfg_div.sv]
// Restoring divider for the interpolation step, one quotient bit per cycle.
// The quotient is known to fit QP_W bits. Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_div (
  input  logic             clk,
  input  logic             rst,
  input  bfg_pkg::div_req_t req,
  output bfg_pkg::div_rsp_t rsp
);
  import bfg_pkg::*;

  localparam int CW = $clog2(QP_W);
  localparam logic [CW-1:0] LAST = CW'(QP_W - 1);

  logic             busy;
  logic             done;
  logic [CW-1:0]    cnt;
  logic [DVS_W-1:0] acc;
  logic [DVS_W-1:0] dvs;
  logic [QP_W-1:0]  shreg;   // low dividend bits out, quotient bits in

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign trial = {acc, shreg[QP_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  assign rsp.done = done;
  assign rsp.quot = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == LAST);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) busy <= 1'b0;
      end
    end
  end

  // upper dividend bits start below the divisor, so QP_W steps suffice
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc   <= req.dividend[DIV_W-1:QP_W];
      shreg <= req.dividend[QP_W-1:0];
      dvs   <= req.divisor;
    end else if (busy) begin
      acc   <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      shreg <= {shreg[QP_W-2:0], ge};
    end
  end

endmodule

[hdl/bfg_front.sv]
// Gauge front end: takes sample beats, sums a burst and queues the finished sum.
// Depends on bfg_pkg and bfg_if.
`timescale 1ns / 1ps

module bfg_front #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic          clk,
  input  logic          rst,
  bfg_sample_if.sink    sample,
  output bfg_pkg::q_wr_t qw,
  input  logic          q_full
);
  import bfg_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(SAMPLES_PER_READING - 1);

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;
  logic [CNT_W-1:0] count;
  logic             last;
  logic             take;

  assign last     = (count >= LAST);
  assign sum_next = sum + SUM_W'(sample.sample_mv);
  // only the closing beat of a burst needs room in the queue
  assign sample.ready = !(last && q_full);
  assign take     = sample.valid && sample.ready;
  assign qw.push  = take && last;
  assign qw.sum   = sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (take) begin
      if (last) begin
        sum   <= '0;
        count <= '0;
      end else begin
        sum   <= sum_next;
        count <= count + 1'b1;
      end
    end
  end

endmodule

[hdl/bfg_back.sv]
// Gauge back end: scales a burst sum to battery millivolts and interpolates the
// charge curve, then holds the result beat. Depends on bfg_pkg, bfg_if, bfg_div.
`timescale 1ns / 1ps

module bfg_back #(
  parameter int SAMPLES_PER_READING = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bfg_pkg::q_rd_t            qr,
  output logic                      q_pop,
  input  logic [bfg_pkg::CAL_W-1:0] cal,
  bfg_result_if.source              result
);
  import bfg_pkg::*;

  localparam logic [BURST_W-1:0] NBURST = BURST_W'(SAMPLES_PER_READING);
  // floor(a / N) = (a * RECIP) >> RS, exact for a below 2^QMV_W
  localparam int RS = QMV_W + BURST_W;
  localparam longint unsigned RECIP_L =
    ((longint'(1) << RS) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
  localparam logic [RS:0] RECIP = (RS+1)'(RECIP_L);
  localparam int PW = QMV_W + RS + 1;

  bk_state_t        state, state_next;
  logic [NUM_W-1:0] num;
  logic [PW-1:0]    prod;
  logic [QMV_W-1:0] mv_raw;
  logic [BURST_W-1:0] r1;
  logic [IDX_W-1:0] idx;
  logic [PCT_W-1:0] pct;
  logic [DH_W-1:0]  diff_hi;
  logic [DH_W-1:0]  dvn;
  logic             res_valid;
  logic [MV_W-1:0]  res_mv;
  logic [PCT_W-1:0] res_pct;

  logic [NUM_W-1:0] num_w;
  logic [PW-1:0]    prod_w;
  logic [QMV_W-1:0] mv_w;
  logic [BURST_W-1:0] r1_w;
  logic [IDX_W-1:0] seg_idx;
  logic             at_top;
  logic             at_bot;
  logic [IDX_W-1:0] prv_idx;
  logic [CMV_W-1:0] cur_mv;
  logic [CMV_W-1:0] prv_mv;
  logic [DV_W-1:0]  dv;
  logic [DP_W-1:0]  dp;
  logic [DV_W-1:0]  diff;
  logic [DH_W-1:0]  diff_hi_w;
  logic [DH_W-1:0]  dvn_w;
  logic [PCT_W:0]   pct_sum;
  logic [PCT_W-1:0] pct_w;
  logic [MV_W-1:0]  mv_sat;
  logic             emit;
  div_req_t         dreq;
  div_rsp_t         drsp;

  bfg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // datapath
  assign num_w  = NUM_W'({qr.sum, 1'b0}) * NUM_W'(cal);
  assign prod_w = PW'(num[NUM_W-1:FRAC_W]) * PW'(RECIP);
  assign mv_w   = prod[RS +: QMV_W];
  assign r1_w   = BURST_W'(num[NUM_W-1:FRAC_W] - QMV_W'(mv_w * QMV_W'(NBURST)));

  assign at_top = (mv_raw >= QMV_W'(curve_mv(IDX_TOP)));
  assign at_bot = (mv_raw < QMV_W'(curve_mv(IDX_BOT))) ||
                  ((mv_raw == QMV_W'(curve_mv(IDX_BOT))) && (r1 == '0) &&
                   (num[FRAC_W-1:0] == '0));

  // lowest-index point at or below the voltage
  always_comb begin
    seg_idx = IDX_BOT;
    for (int i = CURVE_N - 1; i >= 1; i--) begin
      if (mv_raw >= QMV_W'(curve_mv(IDX_W'(i)))) seg_idx = IDX_W'(i);
    end
  end

  assign prv_idx   = IDX_W'(idx - 1'b1);
  assign cur_mv    = curve_mv(idx);
  assign prv_mv    = curve_mv(prv_idx);
  assign dv        = DV_W'(prv_mv - cur_mv);
  assign dp        = DP_W'(curve_pct(prv_idx) - curve_pct(idx));
  assign diff      = DV_W'(mv_raw - QMV_W'(cur_mv));
  // (V - point) in units of 2^-14 / N mV, top part; low bits come from num
  assign diff_hi_w = DH_W'(DH_W'(diff) * DH_W'(NBURST) + DH_W'(r1));
  assign dvn_w     = DH_W'(DH_W'(dv) * DH_W'(NBURST));

  assign pct_sum = {1'b0, curve_pct(idx)} + (PCT_W+1)'(drsp.quot);
  assign pct_w   = (pct_sum > {1'b0, PCT_FULL}) ? PCT_FULL : pct_sum[PCT_W-1:0];
  assign mv_sat  = (mv_raw > QMV_W'(MV_MAX)) ? MV_MAX : mv_raw[MV_W-1:0];

  assign result.valid          = res_valid;
  assign result.battery_mv     = res_mv;
  assign result.charge_percent = res_pct;

  always_comb begin
    state_next    = state;
    q_pop         = 1'b0;
    emit          = 1'b0;
    dreq.start    = 1'b0;
    dreq.dividend = DIV_W'({diff_hi, num[FRAC_W-1:0]}) * DIV_W'(dp);
    dreq.divisor  = {dvn, FRAC_W'(0)};
    unique case (state)
      BK_IDLE: begin
        if (qr.valid) begin
          q_pop      = 1'b1;
          state_next = BK_RECIP;
        end
      end
      BK_RECIP: state_next = BK_REM;
      BK_REM:   state_next = BK_SEG;
      BK_SEG: begin
        if (at_top || at_bot) state_next = BK_EMIT;
        else                  state_next = BK_PREP;
      end
      BK_PREP: state_next = BK_PCT_GO;
      BK_PCT_GO: begin
        dreq.start = 1'b1;
        state_next = BK_PCT_WAIT;
      end
      BK_PCT_WAIT: begin
        if (drsp.done) state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (!res_valid || result.ready) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit)              res_valid <= 1'b1;
      else if (result.ready) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE:  if (qr.valid) num <= num_w;
      BK_RECIP: prod <= prod_w;
      BK_REM: begin
        mv_raw <= mv_w;
        r1     <= r1_w;
      end
      BK_SEG: begin
        idx <= seg_idx;
        if (at_top)      pct <= PCT_FULL;
        else if (at_bot) pct <= PCT_EMPTY;
      end
      BK_PREP: begin
        diff_hi <= diff_hi_w;
        dvn     <= dvn_w;
      end
      BK_PCT_WAIT: if (drsp.done) pct <= pct_w;
      default: ;
    endcase
    if (emit) begin
      res_mv  <= mv_sat;
      res_pct <= pct;
    end
  end

endmodule

[hdl/bfg_check.sv]
// Port-level checks on the fuel gauge result channel, bound to the top level.
// Depends on bfg_pkg and battery_fuel_gauge.
`timescale 1ns / 1ps

module bfg_check (
  input logic                      clk,
  input logic                      rst,
  input logic                      res_valid,
  input logic                      res_ready,
  input logic [bfg_pkg::MV_W-1:0]  battery_mv,
  input logic [bfg_pkg::PCT_W-1:0] charge_percent
);
  import bfg_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(battery_mv) &&
                                $stable(charge_percent))
    else $error("result beat changed while stalled");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> charge_percent <= PCT_FULL)
    else $error("charge percent above full");

  a_pct_full: assert property (@(posedge clk) disable iff (rst)
    res_valid && (battery_mv >= MV_W'(curve_mv(IDX_TOP))) |-> charge_percent == PCT_FULL)
    else $error("full voltage without full charge");

  a_pct_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && (battery_mv < MV_W'(curve_mv(IDX_BOT))) |-> charge_percent == PCT_EMPTY)
    else $error("empty voltage with nonzero charge");

endmodule

bind battery_fuel_gauge bfg_check u_bfg_check (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .battery_mv     (result.battery_mv),
  .charge_percent (result.charge_percent)
);
